// ===== src/rau_pkg.sv =====
// package for the rational arithmetic unit: operation and error codes, widths
`default_nettype none
package rau_pkg;
    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int PROD_W = 64;

    typedef enum logic [2:0] {
        OP_NORM = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_EQ   = 3'd5,
        OP_LT   = 3'd6,
        OP_BAD  = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_DEN  = 2'd1,
        ERR_DIV0 = 2'd2
    } err_t;
endpackage
`default_nettype wire

// ===== src/rau_divider.sv =====
// restoring divider, one quotient bit per cycle, 64-bit unsigned
`default_nettype none
module rau_divider (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [rau_pkg::PROD_W-1:0] dividend,
    input  wire logic [rau_pkg::PROD_W-1:0] divisor,
    output logic                            done,
    output logic      [rau_pkg::PROD_W-1:0] quotient,
    output logic      [rau_pkg::PROD_W-1:0] remainder
);
    localparam int W = rau_pkg::PROD_W;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg, q_reg[W-1]} - {1'b0, d_reg};
        if (start) begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[W]) begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end else begin
                r_next = {r_reg[W-2:0], q_reg[W-1]};
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quotient = q_reg;
    assign remainder = r_reg;

    ap_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without work");
    ap_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider busy at done");
    ap_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !start) |-> cnt_reg != '0)
        else $error("divider count ran out");
endmodule
`default_nettype wire

// ===== src/rational_arithmetic_unit_core.sv =====
// rational arithmetic unit core: sequencer, products, euclid gcd and reduction
// compares, errors and zero numerators skip euclid and the gcd division; all other items
// run the remainder steps of euclid and then divide numerator and denominator by the gcd
// one item at a time, through the shared 64-bit bit-serial divider; s_ready returns
// in the cycle after the result is taken, and the result holds in m_ until taken
// aresetn is synchronous, active low, and clears the sequencer and valid flags
`default_nettype none
module rational_arithmetic_unit_core #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_operation,
    input  wire logic signed [31:0] s_a_num,
    input  wire logic signed [31:0] s_a_den,
    input  wire logic signed [31:0] s_b_num,
    input  wire logic signed [31:0] s_b_den,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [63:0]      m_res_num,
    output logic [62:0]             m_res_den,
    output logic                    m_compare_true,
    output logic [1:0]              m_error_code
);
    localparam int W = rau_pkg::PROD_W;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_P1   = 11'b00000000010,
        S_P2   = 11'b00000000100,
        S_P3   = 11'b00000001000,
        S_COMB = 11'b00000010000,
        S_GST  = 11'b00000100000,
        S_GW   = 11'b00001000000,
        S_QN   = 11'b00010000000,
        S_QD   = 11'b00100000000,
        S_DW   = 11'b01000000000,
        S_OUT  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [63:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [2:0]         op_reg;
    logic signed [63:0] p1_reg, p2_reg, p3_reg;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic signed [63:0] num_comb;
    logic [W-1:0]       num_mag, den_mag;
    logic               den_sign;
    logic               neg_reg;
    logic [W-1:0]       n_reg, d_reg, x_reg, y_reg;
    logic               qd_reg;
    logic signed [63:0] rn_reg;
    logic [62:0]        rd_reg;
    logic               cmp_reg;
    logic [1:0]         err_reg;
    logic               m_valid_reg;

    logic               div_start, div_done;
    logic [W-1:0]       div_dvd, div_dvs, div_q, div_r;

    rau_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_dvd), .divisor(div_dvs),
        .done(div_done), .quotient(div_q), .remainder(div_r)
    );

    function automatic logic signed [63:0] sx(input logic [31:0] v);
        logic [OPERAND_WIDTH-1:0] t;
        t = v[OPERAND_WIDTH-1:0];
        return 64'(signed'(t));
    endfunction

    function automatic logic [W-1:0] mag(input logic signed [63:0] v);
        return v[63] ? W'(-v) : W'(v);
    endfunction

    // one shared 32x32 signed product, one per cycle:
    // p1 = bn*ad, p2 = ad*bd (ad*bn to divide), p3 = an*bd (an*bn to multiply)
    always_comb begin
        mul_a = an_reg[31:0];
        mul_b = bd_reg[31:0];
        case (state_reg)
            S_P1: begin
                mul_a = bn_reg[31:0];
                mul_b = ad_reg[31:0];
            end
            S_P2: begin
                mul_a = ad_reg[31:0];
                mul_b = (op_reg == rau_pkg::OP_DIV) ? bn_reg[31:0] : bd_reg[31:0];
            end
            default: begin
                mul_a = an_reg[31:0];
                mul_b = (op_reg == rau_pkg::OP_MUL) ? bn_reg[31:0] : bd_reg[31:0];
            end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    // numerator and denominator of the unreduced fraction
    always_comb begin
        case (op_reg)
            rau_pkg::OP_ADD: num_comb = p3_reg + p1_reg;
            rau_pkg::OP_SUB: num_comb = p3_reg - p1_reg;
            rau_pkg::OP_MUL, rau_pkg::OP_DIV: num_comb = p3_reg;
            default:         num_comb = an_reg;
        endcase
        num_mag = mag(num_comb);
        den_mag = (op_reg == rau_pkg::OP_NORM) ? mag(ad_reg) : mag(p2_reg);
        den_sign = (op_reg == rau_pkg::OP_NORM) ? ad_reg[63] : p2_reg[63];
    end

    assign div_start = (state_reg == S_GST) || (state_reg == S_QN) || (state_reg == S_QD);
    assign div_dvd = (state_reg == S_GST) ? x_reg : (state_reg == S_QN) ? n_reg : d_reg;
    assign div_dvs = (state_reg == S_GST) ? y_reg : x_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_valid) state_next = S_P1;
            S_P1:   state_next = S_P2;
            S_P2:   state_next = S_P3;
            S_P3:   state_next = S_COMB;
            S_COMB: state_next = (err_reg != rau_pkg::ERR_NONE || op_reg == rau_pkg::OP_EQ
                                  || op_reg == rau_pkg::OP_LT || num_comb == '0) ? S_OUT : S_GST;
            S_GST:  state_next = S_GW;
            S_GW:   if (div_done) state_next = (div_r == '0) ? S_QN : S_GST;
            S_QN:   state_next = S_DW;
            S_DW:   if (div_done) state_next = qd_reg ? S_OUT : S_QD;
            S_QD:   state_next = S_DW;
            S_OUT:  if (m_valid_reg && m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: if (s_valid) begin
                op_reg <= s_operation;
                an_reg <= sx(s_a_num);
                ad_reg <= sx(s_a_den);
                bn_reg <= sx(s_b_num);
                bd_reg <= sx(s_b_den);
                rn_reg <= '0;
                rd_reg <= '0;
                cmp_reg <= 1'b0;
                err_reg <= rau_pkg::ERR_NONE;
            end
            S_P1: begin
                p1_reg <= mul_p;
            end
            S_P2: begin
                p2_reg <= mul_p;
                case (op_reg)
                    rau_pkg::OP_NORM: if (ad_reg == '0) err_reg <= rau_pkg::ERR_DEN;
                    rau_pkg::OP_BAD:  err_reg <= rau_pkg::ERR_DEN;
                    default: begin
                        if (ad_reg <= 0 || bd_reg <= 0) err_reg <= rau_pkg::ERR_DEN;
                        else if (op_reg == rau_pkg::OP_DIV && bn_reg == '0)
                            err_reg <= rau_pkg::ERR_DIV0;
                    end
                endcase
            end
            S_P3: begin
                p3_reg <= mul_p;
            end
            S_COMB: begin
                n_reg <= num_mag;
                d_reg <= den_mag;
                x_reg <= num_mag;
                y_reg <= den_mag;
                neg_reg <= num_comb[63] ^ den_sign;
                if (err_reg == rau_pkg::ERR_NONE) begin
                    if (op_reg == rau_pkg::OP_EQ) cmp_reg <= (p3_reg == p1_reg);
                    else if (op_reg == rau_pkg::OP_LT) cmp_reg <= (p3_reg < p1_reg);
                    else if (num_comb == '0) begin
                        rn_reg <= '0;
                        rd_reg <= 63'd1;
                    end
                end
            end
            S_GW: if (div_done) begin
                x_reg <= y_reg;
                y_reg <= div_r;
            end
            S_QN: qd_reg <= 1'b0;
            S_QD: qd_reg <= 1'b1;
            S_DW: if (div_done) begin
                if (!qd_reg) rn_reg <= neg_reg ? -signed'(div_q) : signed'(div_q);
                else rd_reg <= div_q[62:0];
            end
            default: ;
        endcase
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (state_reg == S_OUT && m_valid_reg && m_ready) m_valid_reg <= 1'b0;
        else if (state_next == S_OUT && state_reg != S_OUT) m_valid_reg <= 1'b1;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_res_num = rn_reg;
    assign m_res_den = rd_reg;
    assign m_compare_true = cmp_reg;
    assign m_error_code = err_reg;

    ap_valid_in_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> state_reg == S_OUT)
        else $error("result valid outside output state");
    ap_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> !s_ready)
        else $error("ready while busy");
    ap_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && err_reg != rau_pkg::ERR_NONE) |-> (rn_reg == '0 && rd_reg == '0))
        else $error("error result with fraction");
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// testbench for the rational arithmetic unit: random and directed items, checked against a predictor
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        rau_pkg::op_t       op;
        logic signed [31:0] an;
        logic signed [31:0] ad;
        logic signed [31:0] bn;
        logic signed [31:0] bd;
        logic               drain;
    } frac_item_t;

    typedef struct packed {
        logic signed [63:0] num;
        logic [62:0]        den;
        logic               cmp;
        rau_pkg::err_t      err;
    } frac_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_operation = '0;
    logic signed [31:0] s_a_num = '0;
    logic signed [31:0] s_a_den = '0;
    logic signed [31:0] s_b_num = '0;
    logic signed [31:0] s_b_den = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [63:0] m_res_num;
    logic [62:0] m_res_den;
    logic m_compare_true;
    logic [1:0] m_error_code;

    frac_item_t   pending_q[$];
    frac_result_t expected_q[$];
    frac_item_t   cur_item;
    int           n_errors = 0;
    int           n_results = 0;
    int           send_gap = 0;
    int           recv_hold = 0;
    bit           long_hold_done = 0;
    bit           quiet;

    rational_arithmetic_unit_core i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_a_num        (s_a_num),
        .s_a_den        (s_a_den),
        .s_b_num        (s_b_num),
        .s_b_den        (s_b_den),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_res_num      (m_res_num),
        .m_res_den      (m_res_den),
        .m_compare_true (m_compare_true),
        .m_error_code   (m_error_code)
    );

    always #5 aclk = ~aclk;

    assign quiet = (pending_q.size() < 150);

    // reduce num/den by their gcd, sign from the operand signs
    function automatic frac_result_t reduce_frac(longint num, longint den);
        frac_result_t r;
        logic [63:0] n, d, x, y, t;
        bit neg;
        r = '0;
        r.err = rau_pkg::ERR_NONE;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? 64'(-num) : 64'(num);
        d = (den < 0) ? 64'(-den) : 64'(den);
        if (n == 0 || d == 0) begin
            r.num = 64'sd0;
            r.den = 63'd1;
            return r;
        end
        x = n;
        y = d;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        n = n / x;
        d = d / x;
        r.num = neg ? -n : n;
        r.den = d[62:0];
        return r;
    endfunction

    function automatic frac_result_t predict_fraction(frac_item_t it);
        frac_result_t r;
        longint an, ad, bn, bd;
        r = '0;
        r.err = rau_pkg::ERR_NONE;
        an = it.an;
        ad = it.ad;
        bn = it.bn;
        bd = it.bd;
        if (it.op == rau_pkg::OP_BAD) begin
            r.err = rau_pkg::ERR_DEN;
        end else if (it.op == rau_pkg::OP_NORM) begin
            if (ad == 0) r.err = rau_pkg::ERR_DEN;
            else r = reduce_frac(an, ad);
        end else if (ad <= 0 || bd <= 0) begin
            r.err = rau_pkg::ERR_DEN;
        end else begin
            case (it.op)
                rau_pkg::OP_ADD: r = reduce_frac(an * bd + bn * ad, ad * bd);
                rau_pkg::OP_SUB: r = reduce_frac(an * bd - bn * ad, ad * bd);
                rau_pkg::OP_MUL: r = reduce_frac(an * bn, ad * bd);
                rau_pkg::OP_DIV: begin
                    if (bn == 0) r.err = rau_pkg::ERR_DIV0;
                    else r = reduce_frac(an * bd, ad * bn);
                end
                rau_pkg::OP_EQ: r.cmp = (an * bd == bn * ad);
                default: r.cmp = (an * bd < bn * ad);
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s at %0t: got %0h, want %0h", what, $realtime, got, want);
        n_errors++;
    endtask

    function automatic logic signed [31:0] rand_operand(bit positive);
        logic signed [31:0] v;
        case ($urandom_range(0, 19))
            0, 1, 2: v = $urandom;
            3, 4, 5, 6: v = $signed(32'($urandom_range(0, 65535))) - 32768;
            default: v = $signed(32'($urandom_range(0, 40))) - 20;
        endcase
        if (positive) begin
            if (v < 0) v = -v;
            if (v <= 0) v = 32'sd1 + $signed(32'($urandom_range(0, 9)));
        end
        return v;
    endfunction

    task automatic add_item(rau_pkg::op_t op, logic signed [31:0] an, logic signed [31:0] ad,
                            logic signed [31:0] bn, logic signed [31:0] bd);
        frac_item_t it;
        it.op = op;
        it.an = an;
        it.ad = ad;
        it.bn = bn;
        it.bd = bd;
        it.drain = 1'b0;
        pending_q.push_back(it);
    endtask

    // sender
    always @(posedge aclk) begin
        logic next_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                expected_q.push_back(predict_fraction(cur_item));
                next_valid = 1'b0;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_q.size() > 0
                             && !(pending_q[0].drain && expected_q.size() > 0)) begin
                    if (!quiet && $urandom_range(0, 11) == 0) begin
                        send_gap = $urandom_range(1, 7) - 1;
                    end else begin
                        cur_item = pending_q.pop_front();
                        next_valid = 1'b1;
                        s_operation <= cur_item.op;
                        s_a_num <= cur_item.an;
                        s_a_den <= cur_item.ad;
                        s_b_num <= cur_item.bn;
                        s_b_den <= cur_item.bd;
                    end
                end
            end
            s_valid <= next_valid;
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        frac_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (expected_q.size() == 0) begin
                    report_mismatch("result with no item outstanding", m_res_num, 64'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_res_num !== want.num) report_mismatch("res_num", m_res_num, want.num);
                    if (m_res_den !== want.den) report_mismatch("res_den", m_res_den, want.den);
                    if (m_compare_true !== want.cmp)
                        report_mismatch("compare_true", m_compare_true, want.cmp);
                    if (m_error_code !== want.err)
                        report_mismatch("error_code", m_error_code, want.err);
                end
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_ready <= 1'b0;
            end else if (!long_hold_done && n_results >= 400) begin
                // long hold-off while the sender keeps offering items
                long_hold_done = 1;
                recv_hold = 3000;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                recv_hold = $urandom_range(1, 7) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        frac_item_t it;
        rau_pkg::op_t op;
        // directed items
        add_item(rau_pkg::OP_NORM, 32'sd6, -32'sd4, 0, 0);
        add_item(rau_pkg::OP_NORM, 32'sd5, 32'sd0, 0, 0);
        add_item(rau_pkg::OP_NORM, 32'sd0, -32'sd7, 0, 0);
        add_item(rau_pkg::OP_NORM, 32'h8000_0000, -32'sd1, 0, 0);
        add_item(rau_pkg::OP_NORM, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff);
        add_item(rau_pkg::OP_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd3);
        add_item(rau_pkg::OP_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        add_item(rau_pkg::OP_SUB, 32'sd1, 32'sd2, 32'sd1, 32'sd2);
        add_item(rau_pkg::OP_SUB, 32'h7fff_ffff, 32'sd1, 32'h8000_0000, 32'h7fff_ffff);
        add_item(rau_pkg::OP_MUL, 32'h8000_0000, 32'sd1, 32'h8000_0000, 32'sd1);
        add_item(rau_pkg::OP_MUL, 32'h7fff_ffff, 32'h7ffe_0001, -32'sd3, 32'sd9);
        add_item(rau_pkg::OP_DIV, 32'sd3, 32'sd4, -32'sd9, 32'sd8);
        add_item(rau_pkg::OP_DIV, 32'sd3, 32'sd4, 32'sd0, 32'sd8);
        add_item(rau_pkg::OP_DIV, 32'sd3, 32'sd0, 32'sd0, 32'sd8);
        add_item(rau_pkg::OP_EQ, 32'sd1, 32'sd2, 32'sd2, 32'sd4);
        add_item(rau_pkg::OP_EQ, 32'sd1, 32'sd2, 32'sd2, 32'sd5);
        add_item(rau_pkg::OP_LT, -32'sd1, 32'sd2, 32'sd0, 32'sd5);
        add_item(rau_pkg::OP_LT, 32'sd1, 32'sd2, 32'sd1, 32'sd2);
        add_item(rau_pkg::OP_LT, 32'sd1, -32'sd2, 32'sd1, 32'sd2);
        add_item(rau_pkg::OP_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd0);
        add_item(rau_pkg::OP_EQ, 32'sd1, 32'h8000_0000, 32'sd1, 32'sd2);
        add_item(rau_pkg::OP_BAD, 32'sd1, 32'sd2, 32'sd3, 32'sd4);
        add_item(rau_pkg::OP_MUL, 32'sd0, 32'sd5, 32'sd7, 32'sd3);
        // random items, mostly with well-formed denominators
        for (int i = 0; i < 1330; i++) begin
            op = rau_pkg::op_t'($urandom_range(0, 7));
            if ($urandom_range(0, 15) == 0) op = rau_pkg::OP_BAD;
            else if (op == rau_pkg::OP_BAD) op = rau_pkg::op_t'($urandom_range(0, 6));
            it.op = op;
            it.an = rand_operand(0);
            it.bn = ($urandom_range(0, 9) == 0) ? 32'sd0 : rand_operand(0);
            it.ad = rand_operand($urandom_range(0, 9) != 0);
            it.bd = rand_operand($urandom_range(0, 9) != 0);
            if ((op == rau_pkg::OP_EQ || op == rau_pkg::OP_LT) && $urandom_range(0, 3) == 0) begin
                it.bn = it.an * 3;
                it.bd = it.ad * 3;
            end
            it.drain = (i == 700);
            pending_q.push_back(it);
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        forever begin
            @(posedge aclk);
            if (pending_q.size() == 0 && !s_valid && expected_q.size() == 0) break;
        end
        repeat (200) @(posedge aclk);
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #500ms;
        $display("tb failed");
        $finish;
    end
endmodule
`default_nettype wire
